// File: rtl/core/hf2bgra_pkg.sv
package hf2bgra_pkg;

  // Largest frame dimension the counters are sized for
  localparam int unsigned MAX_DIMENSION = 8192;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIM_W  = 14;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // binary16 field codes
  localparam logic [4:0] EXP_NONFINITE = 5'd31;
  localparam logic [4:0] EXP_ONE       = 5'd15;
  localparam logic [4:0] SHIFT_BASE    = 5'd25;
  localparam logic [BYTE_W-1:0] UNORM_MAX = 8'hff;

  typedef struct packed {
    logic frame_bad;
    logic frame_end;
    logic row_end;
  } pos_t;

  // Last valid position for a written dimension: zero reads as one,
  // values above the maximum saturate.
  function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] d,
                                                 input logic [16:0] max_dim);
    logic [16:0] d_ext;
    logic [DIM_W-1:0] res;
    d_ext = 17'(d);
    if (d == '0) begin
      res = '0;
    end else if (d_ext > max_dim) begin
      res = DIM_W'(max_dim - 17'd1);
    end else begin
      res = d - DIM_W'(1);
    end
    return res;
  endfunction

  function automatic logic is_nonfinite(input logic [HALF_W-1:0] h);
    return h[14:10] == EXP_NONFINITE;
  endfunction

endpackage

// File: rtl/core/hf2bgra_quant.sv
module hf2bgra_quant (
  input  logic [hf2bgra_pkg::HALF_W-1:0] half_i,
  output logic [hf2bgra_pkg::BYTE_W-1:0] byte_o
);

  logic [4:0]  exp_w;
  logic [4:0]  shift_w;
  logic [10:0] mant_w;
  logic [24:0] prod_w;
  logic [24:0] rnd_w;
  logic [24:0] sum_w;
  logic [24:0] shifted_w;

  assign exp_w   = half_i[14:10];
  assign mant_w  = {1'b1, half_i[9:0]};
  assign shift_w = hf2bgra_pkg::SHIFT_BASE - exp_w;

  // mant * 255 as (mant << 8) - mant
  assign prod_w    = {6'd0, mant_w, 8'd0} - {14'd0, mant_w};
  assign rnd_w     = 25'd1 << (shift_w - 5'd1);
  assign sum_w     = prod_w + rnd_w;
  assign shifted_w = sum_w >> shift_w;

  always_comb begin
    if (half_i[15] || exp_w == '0) begin
      byte_o = '0;
    end else if (exp_w >= hf2bgra_pkg::EXP_ONE) begin
      byte_o = hf2bgra_pkg::UNORM_MAX;
    end else begin
      byte_o = shifted_w[hf2bgra_pkg::BYTE_W-1:0];
    end
  end

endmodule

// File: rtl/core/hf2bgra_pos.sv
module hf2bgra_pos #(
  parameter int unsigned MaxDimension = hf2bgra_pkg::MAX_DIMENSION
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           nonfinite_i,
  input  logic [hf2bgra_pkg::DIM_W-1:0]  width_last_i,
  input  logic [hf2bgra_pkg::DIM_W-1:0]  height_last_i,
  output hf2bgra_pkg::pos_t              pos_o
);

  localparam int unsigned CntW = (MaxDimension > 1) ? $clog2(MaxDimension) : 1;
  localparam int unsigned CmpW = (CntW > hf2bgra_pkg::DIM_W) ? CntW : hf2bgra_pkg::DIM_W;

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic            err_q, err_d;
  logic            row_last_w, frame_last_w, bad_w;

  // A counter already past a shrunken limit ends on the current pixel.
  assign row_last_w   = CmpW'(col_q) >= CmpW'(width_last_i);
  assign frame_last_w = row_last_w && (CmpW'(row_q) >= CmpW'(height_last_i));
  assign bad_w        = err_q || nonfinite_i;

  assign pos_o.row_end   = row_last_w;
  assign pos_o.frame_end = frame_last_w;
  assign pos_o.frame_bad = bad_w;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    err_d = err_q;
    if (step_i) begin
      if (frame_last_w) begin
        col_d = '0;
        row_d = '0;
        err_d = 1'b0;
      end else if (row_last_w) begin
        col_d = '0;
        row_d = row_q + CntW'(1);
        err_d = bad_w;
      end else begin
        col_d = col_q + CntW'(1);
        err_d = bad_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      err_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      err_q <= err_d;
    end
  end

endmodule

// File: rtl/core/half_float_rgba_to_bgra8_top.sv
// A request accepted into the input register moves to the result register
// once that register has room, and is offered on the output from there.
// Throughput: one pixel per cycle; ready follows the result register's room.
// Reset clears both valid flags, the row/column counters and the error flag;
// width and height read as one until written.
module half_float_rgba_to_bgra8_top #(
  parameter int unsigned MaxDimension = hf2bgra_pkg::MAX_DIMENSION
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hf2bgra_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hf2bgra_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // red_half, green_half, blue_half, alpha_half
  input  logic [63:0]                           s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // blue_byte, green_byte, red_byte, alpha_byte
  output logic [31:0]                           m_axis_tdata_o,
  // row_end
  output logic                                  m_axis_tlast_o,
  // frame_end, frame_bad
  output logic [1:0]                            m_axis_tuser_o
);

  localparam logic [16:0] MaxDim17 = 17'(MaxDimension);

  logic [hf2bgra_pkg::DIM_W-1:0] width_last_q, height_last_q;

  logic        in_vld_q;
  logic [63:0] in_data_q;
  logic        out_vld_q;
  logic [31:0] out_data_q;
  logic        out_last_q;
  logic [1:0]  out_user_q;

  logic        out_adv_w;
  logic        step_w;
  logic        nonfinite_w;
  logic [7:0]  red_w, green_w, blue_w, alpha_w;
  hf2bgra_pkg::pos_t pos_w;

  // Config: store the last position, already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= '0;
      height_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hf2bgra_pkg::CFG_FRAME_WIDTH:
          width_last_q <= hf2bgra_pkg::dim_last(cfg_data_i, MaxDim17);
        hf2bgra_pkg::CFG_FRAME_HEIGHT:
          height_last_q <= hf2bgra_pkg::dim_last(cfg_data_i, MaxDim17);
        default: ;
      endcase
    end
  end

  assign out_adv_w       = !out_vld_q || m_axis_tready_i;
  assign step_w          = in_vld_q && out_adv_w;
  assign s_axis_tready_o = !in_vld_q || out_adv_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  hf2bgra_quant u_quant_r (.half_i(in_data_q[15:0]),  .byte_o(red_w));
  hf2bgra_quant u_quant_g (.half_i(in_data_q[31:16]), .byte_o(green_w));
  hf2bgra_quant u_quant_b (.half_i(in_data_q[47:32]), .byte_o(blue_w));
  hf2bgra_quant u_quant_a (.half_i(in_data_q[63:48]), .byte_o(alpha_w));

  assign nonfinite_w = hf2bgra_pkg::is_nonfinite(in_data_q[15:0])
                    || hf2bgra_pkg::is_nonfinite(in_data_q[31:16])
                    || hf2bgra_pkg::is_nonfinite(in_data_q[47:32])
                    || hf2bgra_pkg::is_nonfinite(in_data_q[63:48]);

  hf2bgra_pos #(
    .MaxDimension(MaxDimension)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_w),
    .nonfinite_i  (nonfinite_w),
    .width_last_i (width_last_q),
    .height_last_i(height_last_q),
    .pos_o        (pos_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv_w) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_w) begin
      out_data_q <= {alpha_w, red_w, green_w, blue_w};
      out_last_q <= pos_w.row_end;
      out_user_q <= {pos_w.frame_bad, pos_w.frame_end};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  // Frame end only ever lands on a row end
  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tuser_o[0] || m_axis_tlast_o))
    else $error("frame end without row end");

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A pending input request stays until it moves to the result register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_adv_w) |=> (in_vld_q && m_axis_tvalid_o))
    else $error("pending request lost");

endmodule
